### rtl/hmtp_pkg.sv
// ----------------------------------------------------------------------------
// hmtp_pkg
// Shared types, character codes and helpers for the height map text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hmtp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FILL_COLOR = 2'd2;

  localparam logic [10:0] MAP_WIDTH_RESET  = 11'd1024;
  localparam logic [10:0] MAP_HEIGHT_RESET = 11'd1024;
  localparam logic [31:0] FILL_COLOR_RESET = 32'hFFFF_FFFF;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // height magnitude is capped at 2^32
  localparam logic [32:0] ACC_CAP = 33'h1_0000_0000;

  // result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HSIGN = 3'd1,
    PH_HDIG  = 3'd2,
    PH_HTAIL = 3'd3,
    PH_CLEAD = 3'd4,
    PH_CZERO = 3'd5,
    PH_CHEX  = 3'd6,
    PH_CDONE = 3'd7
  } hmtp_phase_t;

  typedef struct packed {
    logic               kind;
    logic [9:0]         column;
    logic [9:0]         row;
    logic signed [31:0] height;
    logic [31:0]        color;
    logic               error;
  } hmtp_result_t;

  typedef struct packed {
    logic [1:0]   num;
    hmtp_result_t first;
    hmtp_result_t second;
  } hmtp_push_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/hmtp_core.sv
// ----------------------------------------------------------------------------
// hmtp_core
// Per-byte token state, map position and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtp_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                accept,
  input  wire  [7:0]         char_code,
  input  wire                end_of_input,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  output hmtp_pkg::hmtp_push_t push
);
  import hmtp_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int WW = (CW > 11) ? CW : 11;
  localparam int HW = (RW > 11) ? RW : 11;

  logic [10:0] map_width;
  logic [10:0] map_height;
  logic [31:0] fill_color;

  hmtp_phase_t phase;
  logic [32:0] height_accum;
  logic        negative_sign;
  logic        height_digit_seen;
  logic [31:0] color_accum;
  logic        token_error;
  logic        map_error;
  logic [CW-1:0] column_index;
  logic [RW-1:0] row_index;

  // after feeding the byte
  hmtp_phase_t f_phase;
  logic [32:0] f_accum;
  logic        f_neg;
  logic        f_seen;
  logic [31:0] f_color;
  logic        f_terr;

  // token as seen by the close
  hmtp_phase_t t_phase;
  logic [32:0] t_accum;
  logic        t_neg;
  logic        t_seen;
  logic [31:0] t_color;
  logic        t_terr;

  logic [4:0]  hex;
  logic        is_digit;
  logic        is_sep;
  logic        is_nl;
  logic [36:0] acc10;
  logic [32:0] acc_dig;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          do_close;
  logic          in_map;
  logic          point_emit;
  logic          comma;
  logic          tok_err;
  logic [31:0]   mag;
  logic [31:0]   height;
  logic [31:0]   color;
  logic          merr_after;
  logic          end_line;
  logic [RW-1:0] row_after;
  logic [CW-1:0] col_after;
  logic          final_err;
  hmtp_result_t  point_res;
  hmtp_result_t  final_res;

  assign hex      = hex_value(char_code);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_nl    = (char_code == CH_NL);
  assign is_sep   = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                    (char_code == CH_SEMI) || is_nl;

  assign acc10 = ({4'd0, height_accum} << 3) + ({4'd0, height_accum} << 1) +
                 {33'd0, char_code[3:0]};
  assign acc_dig = (acc10 > {4'd0, ACC_CAP}) ? ACC_CAP : acc10[32:0];

  always_comb begin
    f_phase = phase;
    f_accum = height_accum;
    f_neg   = negative_sign;
    f_seen  = height_digit_seen;
    f_color = color_accum;
    f_terr  = token_error;
    unique case (phase)
      PH_IDLE, PH_HSIGN, PH_HDIG: begin
        if (phase == PH_IDLE && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
          f_neg   = (char_code == CH_MINUS);
          f_phase = PH_HSIGN;
        end else if (is_digit) begin
          f_accum = acc_dig;
          f_seen  = 1'b1;
          f_phase = PH_HDIG;
        end else if (char_code == CH_COMMA) begin
          f_phase = PH_CLEAD;
        end else begin
          f_terr  = 1'b1;
          f_phase = PH_HTAIL;
        end
      end
      PH_HTAIL: begin
        if (char_code == CH_COMMA) begin
          f_phase = PH_CLEAD;
        end
      end
      PH_CLEAD, PH_CZERO: begin
        if (phase == PH_CLEAD && char_code == CH_ZERO) begin
          f_phase = PH_CZERO;
        end else if (phase == PH_CZERO && (char_code == CH_X_LO || char_code == CH_X_UP)) begin
          f_phase = PH_CHEX;
        end else if (hex[4]) begin
          f_color = {28'd0, hex[3:0]};
          f_phase = PH_CHEX;
        end else begin
          f_phase = PH_CDONE;
        end
      end
      PH_CHEX: begin
        if (hex[4]) begin
          f_color = {color_accum[27:0], hex[3:0]};
        end else begin
          f_phase = PH_CDONE;
        end
      end
      PH_CDONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (is_sep) begin
      t_phase = phase;
      t_accum = height_accum;
      t_neg   = negative_sign;
      t_seen  = height_digit_seen;
      t_color = color_accum;
      t_terr  = token_error;
    end else begin
      t_phase = f_phase;
      t_accum = f_accum;
      t_neg   = f_neg;
      t_seen  = f_seen;
      t_color = f_color;
      t_terr  = f_terr;
    end
  end

  assign eff_w = (WW'(map_width) > WW'(MAX_COLUMNS)) ? WW'(MAX_COLUMNS) : WW'(map_width);
  assign eff_h = (HW'(map_height) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(map_height);

  assign do_close   = (is_sep || end_of_input) && (t_phase != PH_IDLE);
  assign in_map     = (HW'(row_index) < eff_h) && (WW'(column_index) < eff_w);
  assign point_emit = do_close && in_map;
  assign comma      = (t_phase >= PH_CLEAD);
  assign tok_err    = !t_seen || (comma && t_terr);

  always_comb begin
    if (t_neg) begin
      mag    = (t_accum > 33'h0_8000_0000) ? 32'h8000_0000 : t_accum[31:0];
      height = 32'd0 - mag;
    end else begin
      mag    = t_accum[31:0];
      height = (t_accum > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : t_accum[31:0];
    end
  end

  assign color      = (comma && !tok_err) ? t_color : fill_color;
  assign merr_after = map_error || (point_emit && tok_err);
  assign end_line   = is_nl || end_of_input;
  assign row_after  = (end_line && (HW'(row_index) < eff_h)) ? row_index + RW'(1) : row_index;
  assign col_after  = end_line ? '0 : (point_emit ? column_index + CW'(1) : column_index);
  assign final_err  = merr_after || (HW'(row_after) < eff_h);

  always_comb begin
    point_res.kind   = KIND_POINT;
    point_res.column = 10'(column_index);
    point_res.row    = 10'(row_index);
    point_res.height = height;
    point_res.color  = color;
    point_res.error  = tok_err;
    final_res.kind   = KIND_FINAL;
    final_res.column = '0;
    final_res.row    = '0;
    final_res.height = '0;
    final_res.color  = '0;
    final_res.error  = final_err;
  end

  always_comb begin
    push.num    = accept ? ({1'b0, point_emit} + {1'b0, end_of_input}) : 2'd0;
    push.first  = point_emit ? point_res : final_res;
    push.second = final_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RESET;
      map_height <= MAP_HEIGHT_RESET;
      fill_color <= FILL_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width  <= cfg_data[10:0];
        CFG_MAP_HEIGHT: map_height <= cfg_data[10:0];
        CFG_FILL_COLOR: fill_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      height_accum      <= '0;
      negative_sign     <= 1'b0;
      height_digit_seen <= 1'b0;
      color_accum       <= '0;
      token_error       <= 1'b0;
      map_error         <= 1'b0;
      column_index      <= '0;
      row_index         <= '0;
    end else if (accept) begin
      if (end_of_input) begin
        phase             <= PH_IDLE;
        height_accum      <= '0;
        negative_sign     <= 1'b0;
        height_digit_seen <= 1'b0;
        color_accum       <= '0;
        token_error       <= 1'b0;
        map_error         <= 1'b0;
        column_index      <= '0;
        row_index         <= '0;
      end else begin
        if (is_sep) begin
          phase             <= PH_IDLE;
          height_accum      <= '0;
          negative_sign     <= 1'b0;
          height_digit_seen <= 1'b0;
          color_accum       <= '0;
          token_error       <= 1'b0;
        end else begin
          phase             <= f_phase;
          height_accum      <= f_accum;
          negative_sign     <= f_neg;
          height_digit_seen <= f_seen;
          color_accum       <= f_color;
          token_error       <= f_terr;
        end
        map_error    <= merr_after;
        column_index <= col_after;
        row_index    <= row_after;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hmtp_queue.sv
// ----------------------------------------------------------------------------
// hmtp_queue
// Small result queue taking up to two results per cycle, one out per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtp_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  hmtp_pkg::hmtp_push_t  push,
  input  wire                   pop_stall,
  output logic                  head_valid,
  output hmtp_pkg::hmtp_result_t head,
  output logic                  nearly_full
);
  import hmtp_pkg::*;

  hmtp_result_t    mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic [Q_AW:0]   count_next;
  logic            pop;

  assign head_valid  = (count != '0);
  assign head        = mem[rd_ptr];
  assign pop         = head_valid && !pop_stall;
  assign nearly_full = (count > (Q_AW + 1)'(Q_DEPTH - 2));
  assign count_next  = count + (Q_AW + 1)'(push.num) - (Q_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + Q_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/height_map_text_parser.sv
// ----------------------------------------------------------------------------
// height_map_text_parser
// Parses height map text into point results and a final status result.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while item_stall is low. Each byte updates
// the token and map state in the same cycle and may produce a point result, a
// final status result, or both; results are registered in a four-entry queue
// and leave one per cycle while result_stall is low. The byte input stalls
// while the queue holds more than two results. Configuration is taken at any
// time with cfg_ready always high; there is no clearing pass after reset.
`default_nettype none

module height_map_text_parser #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  wire  [7:0]         char_code,
  input  wire                end_of_input,
  output logic               result_valid,
  input  wire                result_stall,
  output logic               kind,
  output logic [9:0]         column_out,
  output logic [9:0]         row_out,
  output logic signed [31:0] height_out,
  output logic [31:0]        color_out,
  output logic               error,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data
);
  import hmtp_pkg::*;

  hmtp_push_t   push;
  hmtp_result_t head;
  logic         accept;
  logic         nearly_full;

  assign item_stall = nearly_full;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  hmtp_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push)
  );

  hmtp_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop_stall   (result_stall),
    .head_valid  (result_valid),
    .head        (head),
    .nearly_full (nearly_full)
  );

  assign kind       = head.kind;
  assign column_out = head.column;
  assign row_out    = head.row;
  assign height_out = head.height;
  assign color_out  = head.color;
  assign error      = head.error;

endmodule

`default_nettype wire

### rtl/hmtp_checker.sv
// ----------------------------------------------------------------------------
// hmtp_checker
// Port-level checks for the height map text parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtp_checker (
  input wire               clk,
  input wire               rst,
  input wire               item_stall,
  input wire               result_valid,
  input wire               result_stall,
  input wire               kind,
  input wire [9:0]         column_out,
  input wire [9:0]         row_out,
  input wire signed [31:0] height_out,
  input wire [31:0]        color_out,
  input wire               error
);
  import hmtp_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid &&
      $stable({kind, column_out, row_out, height_out, color_out, error}))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("input stalled right after reset");

  a_final_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_FINAL) |->
      column_out == 10'd0 && row_out == 10'd0 && height_out == 32'sd0 &&
      color_out == 32'd0)
    else $error("final status carries point data");

endmodule

bind height_map_text_parser hmtp_checker u_hmtp_checker (.*);

`default_nettype wire
